FILE: design/rtfc_pkg.sv
package rtfc_pkg;

  localparam int MAX_REGIONS = 16;
  localparam int PAGE_BITS   = 12;
  localparam int AW          = $clog2(MAX_REGIONS);
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

  localparam logic [31:0] PAGE_MASK = ~((32'd1 << PAGE_BITS) - 32'd1);

  // action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_FAULT  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  // error bits codes
  localparam logic [1:0] ERR_READ_ABSENT  = 2'd0;
  localparam logic [1:0] ERR_READ_PRESENT = 2'd1;

  // status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_BAD_RANGE    = 3'd1;
  localparam logic [2:0] ST_OVERLAP      = 3'd2;
  localparam logic [2:0] ST_FULL         = 3'd3;
  localparam logic [2:0] ST_NO_REGION    = 3'd4;
  localparam logic [2:0] ST_WRITE_DENIED = 3'd5;
  localparam logic [2:0] ST_READ_PRESENT = 3'd6;
  localparam logic [2:0] ST_READ_DENIED  = 3'd7;

  localparam logic [2:0] FLAG_READ  = 3'd1;
  localparam logic [2:0] FLAG_WRITE = 3'd2;
  localparam logic [2:0] FLAG_EXEC  = 3'd4;
  localparam logic [2:0] PERM_USER  = 3'd4;
  localparam logic [2:0] PERM_WRITE = 3'd2;

  typedef struct packed {
    logic [31:0] rstart;
    logic [31:0] rend;
    logic [2:0]  rflags;
  } region_t;

  typedef struct packed {
    logic load;       // capture item, reset scan
    logic latch_st;   // capture insert status
    logic rd_en;      // read table
    logic rd_prev;    // read at idx-1 instead of idx
    logic take_prev;  // record entry before insert place
    logic take_next;  // record entry after insert place
    logic take_hit;   // record matching region
    logic idx_inc;
    logic idx_dec;
    logic decide;     // pos <= idx, idx <= count
    logic wr_shift;   // write read entry one place up
    logic wr_new;     // write new region, bump count
    logic cnt_clr;
    logic emit;       // load output register
  } rtfc_cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       bad_range;
    logic       cnt_zero;
    logic       cnt_full;
    logic       scan_last;
    logic       le_start;
    logic       hit;
    logic       stop;
    logic       shift_more;
    logic       out_busy;
  } rtfc_sts_t;

endpackage

FILE: design/rtfc_ram.sv
module rtfc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: design/rtfc_ctrl.sv
module rtfc_ctrl import rtfc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  rtfc_sts_t sts_i,
  output rtfc_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_CHK    = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_SHCK   = 4'd5;
  localparam logic [3:0] S_SHWR   = 4'd6;
  localparam logic [3:0] S_PUT    = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  // sequence one item through scan, shift and result
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.act)
          ACT_INSERT: begin
            cmd_o.latch_st = 1'b1;
            if (sts_i.bad_range) state_d = S_FIN;
            else if (sts_i.cnt_zero) state_d = S_DECIDE;
            else state_d = S_RD;
          end
          ACT_FAULT: state_d = sts_i.cnt_zero ? S_FIN : S_RD;
          ACT_CLEAR: begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = S_FIN;
          end
          default: state_d = S_FIN;
        endcase
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_CHK;
      end
      S_CHK: begin
        if (sts_i.act == ACT_INSERT) begin
          if (sts_i.le_start) begin
            cmd_o.take_prev = 1'b1;
            cmd_o.idx_inc   = 1'b1;
            state_d         = sts_i.scan_last ? S_DECIDE : S_RD;
          end else begin
            cmd_o.take_next = 1'b1;
            state_d         = S_DECIDE;
          end
        end else begin
          if (sts_i.hit) begin
            cmd_o.take_hit = 1'b1;
            state_d        = S_FIN;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = sts_i.scan_last ? S_FIN : S_RD;
          end
        end
      end
      S_DECIDE: begin
        cmd_o.latch_st = 1'b1;
        cmd_o.decide   = 1'b1;
        state_d        = (sts_i.stop || sts_i.cnt_full) ? S_FIN : S_SHCK;
      end
      S_SHCK: begin
        if (sts_i.shift_more) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_prev = 1'b1;
          state_d       = S_SHWR;
        end else begin
          state_d = S_PUT;
        end
      end
      S_SHWR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_dec  = 1'b1;
        state_d        = S_SHCK;
      end
      S_PUT: begin
        cmd_o.wr_new = 1'b1;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/rtfc_dp.sv
module rtfc_dp import rtfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rtfc_cmd_t   cmd_i,
  output rtfc_sts_t   sts_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] address_i,
  input  logic [31:0] region_start_i,
  input  logic [31:0] region_end_i,
  input  logic [2:0]  region_flags_i,
  input  logic [1:0]  error_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] found_start_o,
  output logic [31:0] found_end_o,
  output logic [2:0]  found_flags_o,
  output logic [31:0] page_base_o,
  output logic [2:0]  pte_perm_o,
  output logic [31:0] fault_total_o
);

  logic [1:0]       act_q;
  logic [31:0]      addr_q, rs_q, re_q;
  logic [2:0]       rf_q;
  logic [1:0]       eb_q;
  logic [CNT_W-1:0] cnt_q, idx_q, pos_q;
  logic [31:0]      fcnt_q;
  logic [31:0]      prev_end_q, next_start_q;
  logic             have_prev_q, have_next_q, hit_q;
  region_t          hit_q_r;
  logic [2:0]       ins_st_q, ins_st;
  logic             out_valid_q;

  region_t          rdata, wdata;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [CNT_W-1:0] idx_m1, idx_p1;
  logic             overlap, bad_range;
  logic [2:0]       flt_st, res_st;

  assign idx_m1 = idx_q - 1'b1;
  assign idx_p1 = idx_q + 1'b1;

  // region table
  assign raddr = cmd_i.rd_prev ? idx_m1[AW-1:0] : idx_q[AW-1:0];
  assign we    = cmd_i.wr_shift || cmd_i.wr_new;
  assign waddr = cmd_i.wr_new ? pos_q[AW-1:0] : idx_q[AW-1:0];
  assign wdata = cmd_i.wr_new ? region_t'{rstart: rs_q, rend: re_q, rflags: rf_q} : rdata;

  rtfc_ram #(
    .Width($bits(region_t)),
    .Depth(MAX_REGIONS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // insert checks
  assign bad_range = (rs_q >= re_q);
  assign overlap   = (have_prev_q && (prev_end_q > rs_q)) ||
                     (have_next_q && (re_q > next_start_q));
  always_comb begin
    if (bad_range) ins_st = ST_BAD_RANGE;
    else if (overlap) ins_st = ST_OVERLAP;
    else if (cnt_q == CNT_W'(MAX_REGIONS)) ins_st = ST_FULL;
    else ins_st = ST_OK;
  end

  // fault verdict
  always_comb begin
    flt_st = ST_OK;
    if (!hit_q) begin
      flt_st = ST_NO_REGION;
    end else begin
      case (eb_q)
        ERR_READ_PRESENT: flt_st = ST_READ_PRESENT;
        ERR_READ_ABSENT: begin
          if ((hit_q_r.rflags & (FLAG_READ | FLAG_EXEC)) == 3'd0) flt_st = ST_READ_DENIED;
        end
        default: begin
          if ((hit_q_r.rflags & FLAG_WRITE) == 3'd0) flt_st = ST_WRITE_DENIED;
        end
      endcase
    end
  end

  always_comb begin
    case (act_q)
      ACT_INSERT: res_st = ins_st_q;
      ACT_FAULT:  res_st = flt_st;
      default:    res_st = ST_OK;
    endcase
  end

  // status to controller
  assign sts_o.act        = act_q;
  assign sts_o.bad_range  = bad_range;
  assign sts_o.cnt_zero   = (cnt_q == '0);
  assign sts_o.cnt_full   = (cnt_q == CNT_W'(MAX_REGIONS));
  assign sts_o.scan_last  = (idx_p1 == cnt_q);
  assign sts_o.le_start   = (rdata.rstart <= rs_q);
  assign sts_o.hit        = (rdata.rstart <= addr_q) && (addr_q < rdata.rend);
  assign sts_o.stop       = overlap;
  assign sts_o.shift_more = (idx_q > pos_q);
  assign sts_o.out_busy   = out_valid_q && out_stall_i;

  // hold item fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_i;
      addr_q <= address_i;
      rs_q   <= region_start_i;
      re_q   <= region_end_i;
      rf_q   <= region_flags_i;
      eb_q   <= error_bits_i;
    end
    if (cmd_i.take_prev) prev_end_q <= rdata.rend;
    if (cmd_i.take_next) next_start_q <= rdata.rstart;
    if (cmd_i.take_hit) hit_q_r <= rdata;
    if (cmd_i.latch_st) ins_st_q <= ins_st;
    if (cmd_i.decide) pos_q <= idx_q;
  end

  // scan and table control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      fcnt_q      <= '0;
      have_prev_q <= 1'b0;
      have_next_q <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        idx_q       <= '0;
        have_prev_q <= 1'b0;
        have_next_q <= 1'b0;
        hit_q       <= 1'b0;
        if (action_i == ACT_FAULT) fcnt_q <= fcnt_q + 32'd1;
      end
      if (cmd_i.take_prev) have_prev_q <= 1'b1;
      if (cmd_i.take_next) have_next_q <= 1'b1;
      if (cmd_i.take_hit) hit_q <= 1'b1;
      if (cmd_i.idx_inc) idx_q <= idx_p1;
      if (cmd_i.idx_dec) idx_q <= idx_m1;
      if (cmd_i.decide) idx_q <= cnt_q;
      if (cmd_i.wr_new) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.cnt_clr) cnt_q <= '0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_o      <= res_st;
      fault_total_o <= fcnt_q;
      if (act_q == ACT_FAULT && hit_q) begin
        found_start_o <= hit_q_r.rstart;
        found_end_o   <= hit_q_r.rend;
        found_flags_o <= hit_q_r.rflags;
      end else begin
        found_start_o <= '0;
        found_end_o   <= '0;
        found_flags_o <= '0;
      end
      if (act_q == ACT_FAULT && flt_st == ST_OK) begin
        page_base_o <= addr_q & PAGE_MASK;
        pte_perm_o  <= PERM_USER | (((hit_q_r.rflags & FLAG_WRITE) != 3'd0) ? PERM_WRITE : 3'd0);
      end else begin
        page_base_o <= '0;
        pte_perm_o  <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: design/region_table_fault_checker_core.sv
// Region table with fault checking. Holds up to 16 sorted, non-overlapping
// regions in a single-port-read RAM and handles one item at a time. A clear
// or unused action goes straight from dispatch to its result. A fault scans
// the table one entry at a time until it finds the region. An insert with a
// good range scans up to its sorted place; if it overlaps nothing and the
// table is not full, it then moves every later entry up one place and writes
// the new one. A finished result waits in the output register; the next item
// is taken once that result has left the core's sequencer.
module region_table_fault_checker_core import rtfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] address_i,
  input  logic [31:0] region_start_i,
  input  logic [31:0] region_end_i,
  input  logic [2:0]  region_flags_i,
  input  logic [1:0]  error_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] found_start_o,
  output logic [31:0] found_end_o,
  output logic [2:0]  found_flags_o,
  output logic [31:0] page_base_o,
  output logic [2:0]  pte_perm_o,
  output logic [31:0] fault_total_o
);

  rtfc_cmd_t cmd;
  rtfc_sts_t sts;

  rtfc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rtfc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (action_i),
    .address_i     (address_i),
    .region_start_i(region_start_i),
    .region_end_i  (region_end_i),
    .region_flags_i(region_flags_i),
    .error_bits_i  (error_bits_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .found_start_o (found_start_o),
    .found_end_o   (found_end_o),
    .found_flags_o (found_flags_o),
    .page_base_o   (page_base_o),
    .pte_perm_o    (pte_perm_o),
    .fault_total_o (fault_total_o)
  );

  // an accepted item keeps the sequencer busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after accept");

  // never grow a full table
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_new |-> !sts.cnt_full)
    else $error("region written into full table");

  // results appear only from the sequencer
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.emit))
    else $error("result shown without emit");

endmodule

FILE: verif/region_checker.sv
`timescale 1ns / 1ps

module region_checker import rtfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  action_i,
  input  logic [31:0] address_i,
  input  logic [31:0] region_start_i,
  input  logic [31:0] region_end_i,
  input  logic [2:0]  region_flags_i,
  input  logic [1:0]  error_bits_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_i,
  input  logic [31:0] found_start_i,
  input  logic [31:0] found_end_i,
  input  logic [2:0]  found_flags_i,
  input  logic [31:0] page_base_i,
  input  logic [2:0]  pte_perm_i,
  input  logic [31:0] fault_total_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] fstart;
    logic [31:0] fend;
    logic [2:0]  fflags;
    logic [31:0] pbase;
    logic [2:0]  perm;
    logic [31:0] total;
  } outcome_t;

  region_t   table_q [MAX_REGIONS];
  int        used_n;
  logic [31:0] faults_n;
  outcome_t  expected_q [$];
  int        fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  function automatic logic [2:0] add_region(logic [31:0] s, logic [31:0] e, logic [2:0] fl);
    int pos;
    pos = 0;
    if (s >= e) return ST_BAD_RANGE;
    while (pos < used_n && table_q[pos].rstart <= s) pos++;
    if (pos > 0 && table_q[pos-1].rend > s) return ST_OVERLAP;
    if (pos < used_n && e > table_q[pos].rstart) return ST_OVERLAP;
    if (used_n >= MAX_REGIONS) return ST_FULL;
    for (int i = used_n; i > pos; i--) table_q[i] = table_q[i-1];
    table_q[pos] = '{s, e, fl};
    used_n++;
    return ST_OK;
  endfunction

  function automatic outcome_t resolve_item(logic [1:0] act, logic [31:0] addr,
      logic [31:0] s, logic [31:0] e, logic [2:0] fl, logic [1:0] eb);
    outcome_t o;
    int hit;
    o = '0;
    hit = -1;
    case (act)
      ACT_INSERT: o.status = add_region(s, e, fl);
      ACT_CLEAR:  used_n = 0;
      ACT_FAULT: begin
        faults_n++;
        for (int i = 0; i < used_n; i++)
          if (hit < 0 && table_q[i].rstart <= addr && addr < table_q[i].rend) hit = i;
        if (hit < 0) begin
          o.status = ST_NO_REGION;
        end else begin
          o.fstart = table_q[hit].rstart;
          o.fend   = table_q[hit].rend;
          o.fflags = table_q[hit].rflags;
          if (eb == ERR_READ_PRESENT) o.status = ST_READ_PRESENT;
          else if (eb == ERR_READ_ABSENT)
            o.status = (o.fflags & (FLAG_READ | FLAG_EXEC)) == 0 ? ST_READ_DENIED : ST_OK;
          else o.status = (o.fflags & FLAG_WRITE) == 0 ? ST_WRITE_DENIED : ST_OK;
          if (o.status == ST_OK) begin
            o.pbase = addr & PAGE_MASK;
            o.perm  = PERM_USER | ((o.fflags & FLAG_WRITE) != 0 ? PERM_WRITE : 3'd0);
          end
        end
      end
      default: ;
    endcase
    o.total = faults_n;
    return o;
  endfunction

  // predict on accepted input beats, compare on accepted output beats
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t got, want;
    if (!rst_ni) begin
      used_n   = 0;
      faults_n = '0;
      fails    = 0;
      expected_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(resolve_item(action_i, address_i, region_start_i,
                                          region_end_i, region_flags_i, error_bits_i));
      if (out_valid_i && !out_stall_i) begin
        got = '{status_i, found_start_i, found_end_i, found_flags_i,
                page_base_i, pte_perm_i, fault_total_i};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (got.status != want.status) begin
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status); fails++;
          end
          if (got.fstart != want.fstart) begin
            $display("%0t: found_start exp %h got %h", $time, want.fstart, got.fstart); fails++;
          end
          if (got.fend != want.fend) begin
            $display("%0t: found_end exp %h got %h", $time, want.fend, got.fend); fails++;
          end
          if (got.fflags != want.fflags) begin
            $display("%0t: found_flags exp %0d got %0d", $time, want.fflags, got.fflags); fails++;
          end
          if (got.pbase != want.pbase) begin
            $display("%0t: page_base exp %h got %h", $time, want.pbase, got.pbase); fails++;
          end
          if (got.perm != want.perm) begin
            $display("%0t: pte_perm exp %0d got %0d", $time, want.perm, got.perm); fails++;
          end
          if (got.total != want.total) begin
            $display("%0t: fault_total exp %0d got %0d", $time, want.total, got.total); fails++;
          end
        end
      end
    end
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench import rtfc_pkg::*;;

  logic        clk_i, rst_ni;
  logic        in_valid, in_stall, out_valid, out_stall;
  logic [1:0]  action;
  logic [31:0] address, region_start, region_end;
  logic [2:0]  region_flags;
  logic [1:0]  error_bits;
  logic [2:0]  status, found_flags, pte_perm;
  logic [31:0] found_start, found_end, page_base, fault_total;
  int          fail_count, pending;
  int          cycles;
  logic        stim_done;
  logic [31:0] bases [$];

  region_table_fault_checker_core DUT (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .action_i(action), .address_i(address),
    .region_start_i(region_start), .region_end_i(region_end),
    .region_flags_i(region_flags), .error_bits_i(error_bits),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .found_start_o(found_start), .found_end_o(found_end),
    .found_flags_o(found_flags), .page_base_o(page_base),
    .pte_perm_o(pte_perm), .fault_total_o(fault_total)
  );

  region_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .action_i(action), .address_i(address),
    .region_start_i(region_start), .region_end_i(region_end),
    .region_flags_i(region_flags), .error_bits_i(error_bits),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .status_i(status), .found_start_i(found_start), .found_end_i(found_end),
    .found_flags_i(found_flags), .page_base_i(page_base),
    .pte_perm_i(pte_perm), .fault_total_i(fault_total),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // bound the run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 400000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // output side: random stall per beat
  initial begin
    int wait_n;
    out_stall = 1'b1;
    @(posedge rst_ni);
    forever begin
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      @(negedge clk_i);
      out_stall = 1'b1;
      repeat (wait_n) @(negedge clk_i);
      out_stall = 1'b0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // send one beat after a random gap
  task automatic send_beat(logic [1:0] act, logic [31:0] addr, logic [31:0] s,
                           logic [31:0] e, logic [2:0] fl, logic [1:0] eb);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid = 1'b0;
    end
    @(negedge clk_i);
    in_valid = 1'b1; action = act; address = addr;
    region_start = s; region_end = e; region_flags = fl; error_bits = eb;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  function automatic logic [31:0] near_addr();
    logic [31:0] b;
    if (bases.size() == 0 || $urandom_range(0, 4) == 0) return $urandom();
    b = bases[$urandom_range(0, bases.size() - 1)];
    return b + $urandom_range(0, 'h3000) - 'h100;
  endfunction

  initial begin
    logic [31:0] s, e;
    in_valid = 1'b0; action = ACT_NONE; address = '0;
    region_start = '0; region_end = '0; region_flags = '0; error_bits = '0;
    stim_done = 1'b0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table, bad ranges, extremes, overlaps, each fault kind
    send_beat(ACT_FAULT, 32'h0, 0, 0, 3'd0, 2'd0);
    send_beat(ACT_INSERT, 0, 32'h1000, 32'h1000, 3'd7, 2'd0);
    send_beat(ACT_INSERT, 0, 32'h2000, 32'h1000, 3'd7, 2'd0);
    send_beat(ACT_INSERT, 0, 32'h0, 32'h1000, 3'd1, 2'd0);
    send_beat(ACT_INSERT, 0, 32'hFFFF_F000, 32'hFFFF_FFFF, 3'd7, 2'd0);
    send_beat(ACT_INSERT, 0, 32'h5000, 32'h6000, 3'd0, 2'd0);
    send_beat(ACT_INSERT, 0, 32'h3000, 32'h4000, 3'd2, 2'd0);
    send_beat(ACT_INSERT, 0, 32'h3000, 32'h3800, 3'd2, 2'd0);
    send_beat(ACT_INSERT, 0, 32'h3800, 32'h5800, 3'd2, 2'd0);
    send_beat(ACT_INSERT, 0, 32'h2800, 32'h3001, 3'd2, 2'd0);
    for (int k = 0; k < 4; k++) begin
      send_beat(ACT_FAULT, 32'h0000_0ABC, 0, 0, 3'd0, k[1:0]);
      send_beat(ACT_FAULT, 32'h0000_3FFF, 0, 0, 3'd0, k[1:0]);
      send_beat(ACT_FAULT, 32'h0000_5123, 0, 0, 3'd0, k[1:0]);
    end
    send_beat(ACT_FAULT, 32'hFFFF_FFFE, 0, 0, 3'd0, 2'd3);
    send_beat(ACT_FAULT, 32'hFFFF_FFFF, 0, 0, 3'd0, 2'd3);
    send_beat(ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 2'd3);
    // fill to full
    for (int k = 0; k < 13; k++)
      send_beat(ACT_INSERT, 0, 32'h1000_0000 + k * 32'h10000,
                32'h1000_8000 + k * 32'h10000, k[2:0], 2'd0);
    send_beat(ACT_INSERT, 0, 32'h8000_0000, 32'h8000_1000, 3'd7, 2'd0);
    send_beat(ACT_CLEAR, 0, 0, 0, 3'd0, 2'd0);

    // random: mostly well-formed region inserts, clears, unused actions and faults, mostly near the regions
    for (int n = 0; n < 900; n++) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_beat(ACT_CLEAR, $urandom(), $urandom(), $urandom(), 3'($urandom()),
                  2'($urandom()));
        bases.delete();
      end else if (r < 5) begin
        send_beat(ACT_NONE, $urandom(), $urandom(), $urandom(), 3'($urandom()),
                  2'($urandom()));
      end else if (r < 35) begin
        if ($urandom_range(0, 9) == 0) begin
          s = $urandom(); e = $urandom();
        end else begin
          s = {8'($urandom_range(0, 255)), 24'h0} + $urandom_range(0, 'hFFFF);
          e = s + $urandom_range(0, 'h20000);
        end
        send_beat(ACT_INSERT, $urandom(), s, e, 3'($urandom()), 2'($urandom()));
        bases.push_back(s);
      end else begin
        send_beat(ACT_FAULT, near_addr(), $urandom(), $urandom(), 3'($urandom()),
                  2'($urandom()));
      end
    end
    stim_done = 1'b1;

    wait (stim_done && pending == 0);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: region_table_fault_checker_core.f
design/rtfc_pkg.sv
design/rtfc_ram.sv
design/rtfc_ctrl.sv
design/rtfc_dp.sv
design/region_table_fault_checker_core.sv
verif/region_checker.sv
verif/testbench.sv
